// ----- hw/rtl/tr_pkg.sv -----
`default_nettype none

package tr_pkg;

    typedef enum logic [2:0] {
        KIND_DOWN    = 3'd0,
        KIND_MOVE    = 3'd1,
        KIND_UP      = 3'd2,
        KIND_FAULT   = 3'd3,
        KIND_CLEARED = 3'd4,
        KIND_SKIPPED = 3'd5
    } kind_t;

    // Register indexes as seen on paddr[3:2]
    localparam logic [1:0] REG_PIVOT_MODE = 2'd0;
    localparam logic [1:0] REG_X_LIMIT    = 2'd1;
    localparam logic [1:0] REG_Y_LIMIT    = 2'd2;

    localparam logic [11:0] LIMIT_RESET     = 12'hFFF;
    localparam logic [7:0]  STATUS_EMPTY    = 8'h00;
    localparam logic [7:0]  STATUS_INVALID  = 8'h0F;

    typedef struct packed {
        logic       cmd;
        logic       first_in_packet;
        logic [7:0] status_byte;
        logic [7:0] coord_high;
        logic [7:0] x_low;
        logic [7:0] y_low;
        logic [7:0] major_axis;
        logic [7:0] force_req;
    } rec_t;

    typedef struct packed {
        logic        pivot_mode;
        logic [11:0] x_limit;
        logic [11:0] y_limit;
    } cfg_t;

    typedef struct packed {
        kind_t       kind;
        logic [3:0]  slot;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic [7:0]  size_out;
        logic [7:0]  pressure_out;
    } res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tr_apb_regs.sv -----
`default_nettype none

module tr_apb_regs (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output tr_pkg::cfg_t      cfg
);
    import tr_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_PIVOT_MODE: cfg_next.pivot_mode = pwdata[0];
                REG_X_LIMIT:    cfg_next.x_limit    = pwdata[11:0];
                REG_Y_LIMIT:    cfg_next.y_limit    = pwdata[11:0];
                default:        cfg_next            = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pivot_mode <= 1'b0;
            cfg_reg.x_limit    <= LIMIT_RESET;
            cfg_reg.y_limit    <= LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_PIVOT_MODE: prdata = {31'd0, cfg_reg.pivot_mode};
            REG_X_LIMIT:    prdata = {20'd0, cfg_reg.x_limit};
            REG_Y_LIMIT:    prdata = {20'd0, cfg_reg.y_limit};
            default:        prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/tr_decode.sv -----
`default_nettype none

module tr_decode #(
    parameter int MAX_SLOTS = 10
) (
    input  wire tr_pkg::rec_t      rec,
    input  wire tr_pkg::cfg_t      cfg,
    input  wire logic [MAX_SLOTS-1:0] slot_down,
    input  wire logic              skipping,
    output tr_pkg::res_t           res,
    output logic [MAX_SLOTS-1:0]   slot_down_next,
    output logic                   skipping_next
);
    import tr_pkg::*;

    logic [3:0]           nib;
    logic [3:0]           id;
    logic [11:0]          raw_x;
    logic [11:0]          raw_y;
    logic [12:0]          mirror;
    logic [11:0]          px;
    logic [11:0]          py;
    logic                 x_neg;
    logic                 slot_bad;
    logic                 first_bad;
    logic                 fault;
    logic [MAX_SLOTS-1:0] slot_sel;

    assign nib   = rec.status_byte[3:0];
    assign id    = nib - 4'd1;
    assign raw_x = {rec.coord_high[3:0], rec.x_low};
    assign raw_y = {rec.coord_high[7:4], rec.y_low};

    // mirror the swapped x about x_limit; the borrow marks a negative x
    assign mirror = {1'b0, cfg.x_limit} - {1'b0, raw_y};
    assign px     = cfg.pivot_mode ? mirror[11:0] : raw_x;
    assign py     = cfg.pivot_mode ? raw_x : raw_y;
    assign x_neg  = cfg.pivot_mode && mirror[12];

    assign slot_bad  = (nib == 4'd0) || (nib > 4'(MAX_SLOTS));
    assign first_bad = rec.first_in_packet &&
                       ((rec.status_byte == STATUS_EMPTY) ||
                        (rec.status_byte == STATUS_INVALID));
    assign fault = first_bad || slot_bad || x_neg ||
                   (px > cfg.x_limit) || (py > cfg.y_limit);

    always_comb
    begin
        for (int k = 0; k < MAX_SLOTS; k++)
        begin
            slot_sel[k] = (id == 4'(k));
        end
    end

    always_comb
    begin
        res            = '0;
        slot_down_next = slot_down;
        skipping_next  = rec.first_in_packet ? 1'b0 : skipping;
        priority if (rec.cmd)
        begin
            res.kind       = KIND_CLEARED;
            slot_down_next = '0;
            skipping_next  = skipping;
        end
        else if (skipping && !rec.first_in_packet)
        begin
            res.kind = KIND_SKIPPED;
        end
        else if (fault)
        begin
            res.kind       = KIND_FAULT;
            slot_down_next = '0;
            skipping_next  = 1'b1;
        end
        else
        begin
            res.slot  = id;
            res.pos_x = px;
            res.pos_y = py;
            priority if (!rec.status_byte[7])
            begin
                res.kind       = KIND_UP;
                slot_down_next = slot_down & ~slot_sel;
            end
            else if ((slot_down & slot_sel) != '0)
            begin
                res.kind         = KIND_MOVE;
                res.size_out     = rec.major_axis;
                res.pressure_out = rec.force_req;
            end
            else
            begin
                res.kind         = KIND_DOWN;
                res.size_out     = rec.major_axis;
                res.pressure_out = rec.force_req;
                slot_down_next   = slot_down | slot_sel;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/touch_record_decoder.sv -----
// Touch record decoder.
// Input channel: one whole six-byte record per word (in_valid / in_stall),
// plus cmd to release all slots. Output channel: one result word per input
// word (out_valid / out_stall) with kind, slot, position, size and pressure.
// Configuration: APB-style port, pivot_mode at 0x0, x_limit at 0x4,
// y_limit at 0x8; pready is always high. Write only while idle.
// Flow: a taken word lands in the input register; once the result register
// is empty or being taken, it is decoded, updates the slot bits and has its
// result registered, raising out_valid. Throughput: one word per cycle while
// out_stall holds no result, set by the single decode pass between the input
// and result registers, which also reads and writes the slot bits in that cycle.
// Stall: while out_stall holds a result, the input register keeps its word
// and in_stall rises; an empty input register still takes a word.
// Reset: all slots up, no packet being skipped, pivot off, both limits 4095,
// both registers empty.

`default_nettype none

module touch_record_decoder #(
    parameter int MAX_SLOTS = 10
) (
    input  wire logic         clk,
    input  wire logic         rst_n,

    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,

    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire logic         cmd,
    input  wire logic         first_in_packet,
    input  wire logic [7:0]   status_byte,
    input  wire logic [7:0]   coord_high,
    input  wire logic [7:0]   x_low,
    input  wire logic [7:0]   y_low,
    input  wire logic [7:0]   major_axis,
    input  wire logic [7:0]   force_req,

    output logic              out_valid,
    input  wire logic         out_stall,
    output tr_pkg::kind_t     kind,
    output logic [3:0]        slot,
    output logic [11:0]       pos_x,
    output logic [11:0]       pos_y,
    output logic [7:0]        size_out,
    output logic [7:0]        pressure_out
);
    import tr_pkg::*;

    cfg_t                 cfg;
    rec_t                 in_reg;
    logic                 in_valid_reg;
    res_t                 out_reg;
    logic                 out_valid_reg;
    logic [MAX_SLOTS-1:0] slot_down_reg;
    logic [MAX_SLOTS-1:0] slot_down_next;
    logic                 skipping_reg;
    logic                 skipping_next;
    res_t                 res;
    logic                 advance;
    logic                 fire;
    logic                 take;

    tr_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tr_decode #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_decode (
        .rec            (in_reg),
        .cfg            (cfg),
        .slot_down      (slot_down_reg),
        .skipping       (skipping_reg),
        .res            (res),
        .slot_down_next (slot_down_next),
        .skipping_next  (skipping_next)
    );

    // result register frees up when empty or being taken
    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;
    assign take     = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            slot_down_reg <= '0;
            skipping_reg  <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire)
            begin
                slot_down_reg <= slot_down_next;
                skipping_reg  <= skipping_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_reg.cmd             <= cmd;
            in_reg.first_in_packet <= first_in_packet;
            in_reg.status_byte     <= status_byte;
            in_reg.coord_high      <= coord_high;
            in_reg.x_low           <= x_low;
            in_reg.y_low           <= y_low;
            in_reg.major_axis      <= major_axis;
            in_reg.force_req       <= force_req;
        end
        if (fire)
        begin
            out_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = out_reg.kind;
    assign slot         = out_reg.slot;
    assign pos_x        = out_reg.pos_x;
    assign pos_y        = out_reg.pos_y;
    assign size_out     = out_reg.size_out;
    assign pressure_out = out_reg.pressure_out;

    // a fault drops every slot and starts skipping
    a_fault_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (res.kind == KIND_FAULT) |=> (slot_down_reg == '0) && skipping_reg)
        else $error("fault did not clear slots or set skipping");

    a_clear_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (res.kind == KIND_CLEARED) |=> (slot_down_reg == '0))
        else $error("clear command left a slot down");

    a_skip_source: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (res.kind == KIND_SKIPPED) |-> skipping_reg && !in_reg.first_in_packet)
        else $error("skipped result without an active skip");

    a_no_extras: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_reg.kind != KIND_DOWN) && (out_reg.kind != KIND_MOVE)
        |-> (out_reg.size_out == 8'd0) && (out_reg.pressure_out == 8'd0))
        else $error("size or pressure on a non-touch result");

    a_stall_holds_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg && out_valid_reg)
        else $error("input stalled with no pending word");

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    import tr_pkg::*;

    localparam int NUM_SLOTS   = 10;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic        in_valid = 1'b0;
    logic        in_stall;
    rec_t        in_word = '0;

    logic        out_valid;
    logic        out_stall = 1'b0;
    kind_t       kind;
    logic [3:0]  slot;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [7:0]  size_out;
    logic [7:0]  pressure_out;

    // records waiting to be offered, results waiting to come out
    rec_t        record_q[$];
    res_t        decoded_q[$];

    // predictor state
    cfg_t        cur_cfg;
    logic        slot_is_down [NUM_SLOTS];
    logic        skip_packet;

    int          idle_pct = 0;
    int          stall_pct = 0;
    bit          hold_request = 1'b0;
    bit          hold_taken = 1'b0;
    int          hold_left = 0;
    int          cycle_cnt = 0;
    int          errors = 0;

    touch_record_decoder #(
        .MAX_SLOTS(NUM_SLOTS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (in_word.cmd),
        .first_in_packet(in_word.first_in_packet),
        .status_byte    (in_word.status_byte),
        .coord_high     (in_word.coord_high),
        .x_low          (in_word.x_low),
        .y_low          (in_word.y_low),
        .major_axis     (in_word.major_axis),
        .force_req      (in_word.force_req),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .slot           (slot),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .size_out       (size_out),
        .pressure_out   (pressure_out)
    );

    always #4 clk = ~clk;

    function automatic void release_all_slots();
        for (int k = 0; k < NUM_SLOTS; k++)
        begin
            slot_is_down[k] = 1'b0;
        end
    endfunction

    function automatic res_t decode_record(rec_t r);
        res_t res;
        int   slot_id;
        int   px;
        int   py;
        int   swap;
        res = '0;
        if (r.cmd)
        begin
            release_all_slots();
            res.kind = KIND_CLEARED;
            return res;
        end
        if (r.first_in_packet)
            skip_packet = 1'b0;
        if (skip_packet)
        begin
            res.kind = KIND_SKIPPED;
            return res;
        end
        slot_id = int'(r.status_byte[3:0]) - 1;
        px = int'({r.coord_high[3:0], r.x_low});
        py = int'({r.coord_high[7:4], r.y_low});
        // pivot: swap axes, then mirror x about its limit
        if (cur_cfg.pivot_mode)
        begin
            swap = px;
            px = py;
            py = swap;
            px = int'(cur_cfg.x_limit) - px;
        end
        if ((r.first_in_packet && (r.status_byte == STATUS_EMPTY ||
                                   r.status_byte == STATUS_INVALID)) ||
            slot_id < 0 || slot_id >= NUM_SLOTS ||
            px < 0 || px > int'(cur_cfg.x_limit) || py > int'(cur_cfg.y_limit))
        begin
            release_all_slots();
            skip_packet = 1'b1;
            res.kind = KIND_FAULT;
            return res;
        end
        res.slot  = slot_id[3:0];
        res.pos_x = px[11:0];
        res.pos_y = py[11:0];
        if (!r.status_byte[7])
        begin
            slot_is_down[slot_id] = 1'b0;
            res.kind = KIND_UP;
        end
        else
        begin
            res.kind = slot_is_down[slot_id] ? KIND_MOVE : KIND_DOWN;
            slot_is_down[slot_id] = 1'b1;
            res.size_out = r.major_axis;
            res.pressure_out = r.force_req;
        end
        return res;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // sender: offer a new word once the current one is taken
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                decoded_q.push_back(decode_record(in_word));
            if (!in_valid || !in_stall)
            begin
                if (record_q.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    in_word <= record_q.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver stall, with one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_request && !hold_taken)
        begin
            hold_taken <= 1'b1;
            hold_left <= LONG_HOLD;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin : result_check
        res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (decoded_q.size() == 0)
            begin
                $display("%0t: result word with none expected, kind %0d", $time, kind);
                errors++;
            end
            else
            begin
                want = decoded_q.pop_front();
                check_field("kind", want.kind, kind);
                check_field("slot", want.slot, slot);
                check_field("pos_x", want.pos_x, pos_x);
                check_field("pos_y", want.pos_y, pos_y);
                check_field("size_out", want.size_out, size_out);
                check_field("pressure_out", want.pressure_out, pressure_out);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("%0t: timeout", $time);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value,
                             input logic [31:0] mask);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        // back-to-back read of the same register
        @(posedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        check_field("prdata", value & mask, prdata & mask);
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (record_q.size() != 0 || in_valid || decoded_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_phase(input int idle, input int stall, input logic pivot,
                             input logic [11:0] xlim, input logic [11:0] ylim);
        wait_drained();
        repeat (3) @(posedge clk);
        write_reg(REG_PIVOT_MODE, {31'd0, pivot}, 32'h1);
        write_reg(REG_X_LIMIT, {20'd0, xlim}, 32'hFFF);
        write_reg(REG_Y_LIMIT, {20'd0, ylim}, 32'hFFF);
        cur_cfg.pivot_mode = pivot;
        cur_cfg.x_limit = xlim;
        cur_cfg.y_limit = ylim;
        idle_pct = idle;
        stall_pct = stall;
    endtask

    task automatic add_record(input logic cmd_bit, input logic first_bit,
                              input logic [7:0] st, input logic [11:0] raw_x,
                              input logic [11:0] raw_y, input logic [7:0] mj,
                              input logic [7:0] fr);
        rec_t r;
        r.cmd = cmd_bit;
        r.first_in_packet = first_bit;
        r.status_byte = st;
        r.coord_high = {raw_y[11:8], raw_x[11:8]};
        r.x_low = raw_x[7:0];
        r.y_low = raw_y[7:0];
        r.major_axis = mj;
        r.force_req = fr;
        record_q.push_back(r);
    endtask

    function automatic logic [11:0] pick_coord(input int lim);
        int sel;
        sel = $urandom_range(99);
        if (sel < 10)
            return 12'd0;
        if (sel < 20)
            return lim[11:0];
        return 12'($urandom_range(lim));
    endfunction

    // packets of one to four records, mostly well formed
    task automatic queue_packets(input int count);
        int         added;
        int         len;
        int         sel;
        int         slot_no;
        logic       first_bit;
        logic [7:0] st;
        logic [11:0] rx;
        logic [11:0] ry;
        added = 0;
        while (added < count)
        begin
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++)
            begin
                sel = $urandom_range(99);
                if (sel < 3)
                    add_record(1'b1, 1'($urandom_range(1)), 8'($urandom_range(255)),
                               12'($urandom_range(4095)), 12'($urandom_range(4095)),
                               8'($urandom_range(255)), 8'($urandom_range(255)));
                else if (sel < 10)
                    add_record(1'b0, 1'($urandom_range(1)), 8'($urandom_range(255)),
                               12'($urandom_range(4095)), 12'($urandom_range(4095)),
                               8'($urandom_range(255)), 8'($urandom_range(255)));
                else
                begin
                    first_bit = (i == 0);
                    if ($urandom_range(99) < 4)
                        first_bit = ~first_bit;
                    slot_no = $urandom_range(NUM_SLOTS - 1);
                    st[7] = 1'($urandom_range(1));
                    st[6:4] = 3'($urandom_range(7));
                    st[3:0] = 4'(slot_no + 1);
                    if ($urandom_range(99) < 5)
                        st[3:0] = 4'($urandom_range(15));
                    if (first_bit && $urandom_range(99) < 3)
                        st = $urandom_range(1) ? STATUS_EMPTY : STATUS_INVALID;
                    if ($urandom_range(99) < 6)
                    begin
                        rx = 12'($urandom_range(4095));
                        ry = 12'($urandom_range(4095));
                    end
                    else if (cur_cfg.pivot_mode)
                    begin
                        // raw x lands on y, raw y is mirrored onto x
                        rx = pick_coord(int'(cur_cfg.y_limit));
                        ry = pick_coord(int'(cur_cfg.x_limit));
                    end
                    else
                    begin
                        rx = pick_coord(int'(cur_cfg.x_limit));
                        ry = pick_coord(int'(cur_cfg.y_limit));
                    end
                    add_record(1'b0, first_bit, st, rx, ry,
                               8'($urandom_range(255)), 8'($urandom_range(255)));
                end
                added++;
            end
        end
    endtask

    initial
    begin
        cur_cfg.pivot_mode = 1'b0;
        cur_cfg.x_limit = LIMIT_RESET;
        cur_cfg.y_limit = LIMIT_RESET;
        release_all_slots();
        skip_packet = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        set_phase(0, 0, 1'b0, LIMIT_RESET, LIMIT_RESET);
        add_record(1'b0, 1'b1, 8'h81, 12'd0, 12'd0, 8'h00, 8'h00);
        add_record(1'b0, 1'b0, 8'h81, 12'hFFF, 12'hFFF, 8'hFF, 8'hFF);
        add_record(1'b0, 1'b0, 8'h01, 12'h5A5, 12'hA5A, 8'hFF, 8'hFF);
        add_record(1'b0, 1'b1, 8'h8A, 12'h123, 12'h456, 8'h55, 8'hAA);
        add_record(1'b1, 1'b1, 8'hFF, 12'hFFF, 12'hFFF, 8'hFF, 8'hFF);
        add_record(1'b0, 1'b0, 8'hFA, 12'hA5A, 12'h5A5, 8'hAA, 8'h55);
        add_record(1'b0, 1'b1, STATUS_EMPTY, 12'd10, 12'd10, 8'h01, 8'h01);
        add_record(1'b0, 1'b0, 8'h81, 12'd20, 12'd20, 8'h02, 8'h02);
        add_record(1'b1, 1'b0, 8'h81, 12'd0, 12'd0, 8'h00, 8'h00);
        add_record(1'b0, 1'b0, 8'h81, 12'd30, 12'd30, 8'h03, 8'h03);
        add_record(1'b0, 1'b1, STATUS_INVALID, 12'd40, 12'd40, 8'h04, 8'h04);
        add_record(1'b0, 1'b1, 8'h8B, 12'd50, 12'd50, 8'h05, 8'h05);
        add_record(1'b0, 1'b1, 8'h83, 12'd60, 12'd60, 8'h06, 8'h06);
        add_record(1'b0, 1'b0, 8'h00, 12'd70, 12'd70, 8'h07, 8'h07);
        add_record(1'b0, 1'b1, 8'h8F, 12'd80, 12'd80, 8'h08, 8'h08);
        add_record(1'b0, 1'b1, 8'h70, 12'd90, 12'd90, 8'h09, 8'h09);
        queue_packets(300);

        set_phase(51, 0, 1'b1, LIMIT_RESET, LIMIT_RESET);
        queue_packets(300);

        set_phase(0, 51, 1'b1, 12'd2000, 12'd3000);
        add_record(1'b0, 1'b1, 8'h82, 12'd3000, 12'd0, 8'h11, 8'h22);
        add_record(1'b0, 1'b1, 8'h82, 12'd0, 12'd2000, 8'h33, 8'h44);
        add_record(1'b0, 1'b1, 8'h82, 12'd0, 12'd2001, 8'h55, 8'h66);
        add_record(1'b0, 1'b1, 8'h82, 12'd3001, 12'd0, 8'h77, 8'h88);
        queue_packets(300);

        set_phase(23, 23, 1'b0, 12'd1023, 12'd2047);
        add_record(1'b0, 1'b1, 8'h85, 12'd1023, 12'd2047, 8'h12, 8'h34);
        add_record(1'b0, 1'b1, 8'h85, 12'd1024, 12'd0, 8'h56, 8'h78);
        add_record(1'b0, 1'b0, 8'h85, 12'd0, 12'd2048, 8'h9A, 8'hBC);
        queue_packets(300);

        set_phase(0, 0, 1'b1, 12'd0, LIMIT_RESET);
        queue_packets(150);

        set_phase(23, 23, 1'b0, LIMIT_RESET, 12'd0);
        queue_packets(150);

        // hold the receiver off while the sender keeps offering words
        set_phase(0, 0, 1'b0, LIMIT_RESET, LIMIT_RESET);
        hold_request = 1'b1;
        queue_packets(150);

        wait_drained();
        repeat (5) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/tr_pkg.sv
hw/rtl/tr_apb_regs.sv
hw/rtl/tr_decode.sv
hw/rtl/touch_record_decoder.sv
verif/testbench.sv
